>>> hw/rtl/grc_pkg.sv
`timescale 1ns / 1ps

package grc_pkg;

    localparam int MAP_COLS_DEF    = 32;
    localparam int MAP_ROWS_DEF    = 32;
    localparam int ANGLE_STEPS_DEF = 1024;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_W       = 32;

    typedef struct packed {
        logic [15:0] viewer_x;
        logic [15:0] viewer_y;
        logic [9:0]  view_heading;
        logic [9:0]  view_span;
        logic [15:0] max_depth;
        logic [10:0] march_step;
        logic [11:0] screen_width;
        logic [11:0] screen_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        viewer_x:      16'd2048,
        viewer_y:      16'd2048,
        view_heading:  10'd0,
        view_span:     10'd128,
        max_depth:     16'd4096,
        march_step:    11'd26,
        screen_width:  12'd640,
        screen_height: 12'd480
    };

    // One queued request after classification by the front end.
    typedef struct packed {
        logic        cast;
        logic        wr_ok;
        logic        wall;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [10:0] column_x;
    } t_req;

endpackage

>>> hw/rtl/grc_ifs.sv
`timescale 1ns / 1ps

interface grc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [4:0]  cell_row;
    logic [4:0]  cell_col;
    logic        cell_wall;
    logic [10:0] column_x;

    modport source (output valid, func, cell_row, cell_col, cell_wall, column_x, input ready);
    modport sink   (input valid, func, cell_row, cell_col, cell_wall, column_x, output ready);
endinterface

interface grc_out_if;
    logic               valid;
    logic               ready;
    logic [10:0]        out_column;
    logic [15:0]        hit_distance;
    logic signed [15:0] ceiling_row;
    logic [15:0]        floor_row;
    logic [7:0]         wall_red;
    logic [7:0]         wall_green;
    logic [7:0]         wall_blue;

    modport source (output valid, out_column, hit_distance, ceiling_row, floor_row,
                    wall_red, wall_green, wall_blue, input ready);
    modport sink   (input valid, out_column, hit_distance, ceiling_row, floor_row,
                    wall_red, wall_green, wall_blue, output ready);
endinterface

>>> hw/rtl/grc_front.sv
`timescale 1ns / 1ps

module grc_front #(
    parameter int MAP_COLS = grc_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = grc_pkg::MAP_ROWS_DEF
) (
    grc_in_if.sink         i_req,
    input  logic           i_full,
    output logic           o_push,
    output grc_pkg::t_req  o_data
);

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_data.cast     = i_req.func;
        o_data.wr_ok    = (int'(i_req.cell_row) < MAP_ROWS) && (int'(i_req.cell_col) < MAP_COLS);
        o_data.wall     = i_req.cell_wall;
        o_data.row      = i_req.cell_row;
        o_data.col      = i_req.cell_col;
        o_data.column_x = i_req.column_x;
    end

endmodule

>>> hw/rtl/grc_fifo.sv
`timescale 1ns / 1ps

module grc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  grc_pkg::t_req  i_data,
    input  logic           i_pop,
    output grc_pkg::t_req  o_data,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = $clog2(grc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(grc_pkg::QUEUE_DEPTH + 1);

    grc_pkg::t_req r_mem [grc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(grc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(grc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(grc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/grc_div.sv
`timescale 1ns / 1ps

module grc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [grc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [grc_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [grc_pkg::DIV_W-1:0]  o_quot
);

    localparam int W  = grc_pkg::DIV_W;
    localparam int NW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_dvs;
    logic [W:0]    w_sh;
    logic [W:0]    w_diff;

    assign w_sh   = {r_rem[W-1:0], r_quot[W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_diff[W] ? w_sh : w_diff;
            r_quot <= {r_quot[W-2:0], ~w_diff[W]};
        end
    end

endmodule

>>> hw/rtl/grc_back.sv
`timescale 1ns / 1ps

module grc_back #(
    parameter int MAP_COLS    = grc_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = grc_pkg::MAP_ROWS_DEF,
    parameter int ANGLE_STEPS = grc_pkg::ANGLE_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  grc_pkg::t_cfg  i_cfg,
    input  grc_pkg::t_req  i_req,
    input  logic           i_empty,
    output logic           o_pop,
    grc_out_if.source      o_res
);

    // ANGLE_STEPS is a power of two, so the angle wrap is a mask and the phase a shift.
    localparam int CELLS = MAP_ROWS * MAP_COLS;
    localparam int MA_W  = $clog2(CELLS);
    localparam int ANG_W = $clog2(ANGLE_STEPS);
    localparam int POS_W = 34;
    localparam int DW    = grc_pkg::DIV_W;

    localparam logic signed [22:0] C_MIN = -23'sd32768;

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_NUM0   = 17'h00002,
        S_NUM1   = 17'h00004,
        S_DQ_GO  = 17'h00008,
        S_DQ_WT  = 17'h00010,
        S_TZ     = 17'h00020,
        S_T1     = 17'h00040,
        S_T2     = 17'h00080,
        S_T3     = 17'h00100,
        S_TSTEP  = 17'h00200,
        S_MSTART = 17'h00400,
        S_LOOK   = 17'h00800,
        S_TEST   = 17'h01000,
        S_DC_MUL = 17'h02000,
        S_DC_GO  = 17'h04000,
        S_DC_WT  = 17'h08000,
        S_FIN    = 17'h10000
    } t_state;

    t_state                r_state;
    logic                  r_map [CELLS];
    logic                  r_cell;
    logic [10:0]           r_x;
    logic [DW-1:0]         r_num;
    logic [16:0]           r_phase;
    logic                  r_cos;
    logic                  r_neg;
    logic [15:0]           r_z;
    logic [15:0]           r_z2;
    logic [15:0]           r_r;
    logic signed [15:0]    r_s;
    logic signed [27:0]    r_dx;
    logic signed [27:0]    r_dy;
    logic [16:0]           r_d;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic                  r_out;
    logic [15:0]           r_dd;
    logic signed [30:0]    r_cnum;
    logic                  r_cneg;
    logic signed [22:0]    r_c;
    logic                  r_zero;
    logic                  r_ov;
    logic [10:0]           r_o_col;
    logic [15:0]           r_o_dist;
    logic signed [15:0]    r_o_ceil;
    logic [15:0]           r_o_floor;
    logic [7:0]            r_o_red;
    logic [7:0]            r_o_green;
    logic [7:0]            r_o_blue;

    logic [11:0]           w_w;
    logic [10:0]           w_step;
    logic [16:0]           w_k;
    logic signed [12:0]    w_twox;
    logic signed [23:0]    w_span_prod;
    logic [16:0]           w_ph;
    logic [15:0]           w_zraw;
    logic [15:0]           w_z;
    logic [31:0]           w_p0;
    logic [31:0]           w_p1;
    logic [31:0]           w_p2;
    logic [31:0]           w_p3;
    logic [15:0]           w_s;
    logic signed [27:0]    w_sprod;
    logic                  w_outside;
    logic [MA_W-1:0]       w_raddr;
    logic [MA_W-1:0]       w_waddr;
    logic                  w_we;
    logic [15:0]           w_dd;
    logic signed [30:0]    w_cnum;
    logic [30:0]           w_cmag;
    logic signed [23:0]    w_floor;
    logic [17:0]           w_dd2;
    logic [17:0]           w_dd3;
    logic [17:0]           w_dd4;
    logic [17:0]           w_max;
    logic                  w_load;
    logic                  w_div_start;
    logic [DW-1:0]         w_div_a;
    logic [DW-1:0]         w_div_b;
    logic                  w_div_done;
    logic [DW-1:0]         w_div_q;

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    assign w_w    = (i_cfg.screen_width == '0) ? 12'd1 : i_cfg.screen_width;
    assign w_step = (i_cfg.march_step == '0) ? 11'd1 : i_cfg.march_step;

    assign w_k         = ({7'b0, i_cfg.view_heading} << 1) + 17'(8 * ANGLE_STEPS);
    assign w_twox      = $signed({1'b0, r_x, 1'b0}) - $signed({1'b0, w_w});
    assign w_span_prod = $signed({1'b0, i_cfg.view_span}) * w_twox;

    assign w_ph   = r_cos ? r_phase + 17'd32768 : r_phase;
    assign w_zraw = {1'b0, w_ph[14:0]};
    assign w_z    = w_ph[15] ? 16'd32768 - w_zraw : w_zraw;
    assign w_p0   = 32'(w_z) * 32'(w_z);
    assign w_p1   = 32'(r_z2) * 32'd1160;
    assign w_p2   = 32'(16'd10512 - r_r) * 32'(r_z2);
    assign w_p3   = 32'(16'd25736 - r_r) * 32'(r_z);
    assign w_s    = 16'(w_p3 >> 15);
    assign w_sprod = r_s * $signed({1'b0, w_step});

    assign w_outside = r_px[POS_W-1] || r_py[POS_W-1]
                    || (int'(r_px[POS_W-2:22]) >= MAP_COLS)
                    || (int'(r_py[POS_W-2:22]) >= MAP_ROWS);
    assign w_raddr = MA_W'(32'(r_py[POS_W-2:22]) * 32'(MAP_COLS) + 32'(r_px[POS_W-2:22]));
    assign w_waddr = MA_W'(32'(i_req.row) * 32'(MAP_COLS) + 32'(i_req.col));

    assign o_pop = (r_state == S_IDLE) && !i_empty;
    assign w_we  = o_pop && !i_req.cast && i_req.wr_ok;

    assign w_dd   = r_d[16] ? 16'hFFFF : r_d[15:0];
    assign w_cnum = $signed({1'b0, i_cfg.screen_height}) * ($signed({2'b0, w_dd}) - 18'sd512);
    assign w_cmag = r_cnum[30] ? 31'(-r_cnum) : 31'(r_cnum);

    assign w_floor = $signed({12'b0, i_cfg.screen_height}) + 24'sd48 - 24'(r_c);
    assign w_dd2   = {2'b0, r_dd} << 1;
    assign w_dd3   = 18'({2'b0, r_dd} * 18'd3);
    assign w_dd4   = {2'b0, r_dd} << 2;
    assign w_max   = {2'b0, i_cfg.max_depth};
    assign w_load  = (r_state == S_FIN) && (!r_ov || o_res.ready);

    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = r_num;
        w_div_b     = {19'b0, w_w, 1'b0};
        unique case (r_state)
            S_DQ_GO: begin
                w_div_start = 1'b1;
            end
            S_DC_GO: begin
                w_div_start = 1'b1;
                w_div_a     = {1'b0, w_cmag};
                w_div_b     = {15'b0, r_dd, 1'b0};
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= i_req.wall;
        end
        r_cell <= r_map[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty && i_req.cast) begin
                        r_state <= S_NUM0;
                    end
                end
                S_NUM0:   r_state <= S_NUM1;
                S_NUM1:   r_state <= S_DQ_GO;
                S_DQ_GO:  r_state <= S_DQ_WT;
                S_DQ_WT: begin
                    if (w_div_done) begin
                        r_state <= S_TZ;
                    end
                end
                S_TZ:     r_state <= S_T1;
                S_T1:     r_state <= S_T2;
                S_T2:     r_state <= S_T3;
                S_T3:     r_state <= S_TSTEP;
                S_TSTEP:  r_state <= r_cos ? S_MSTART : S_TZ;
                S_MSTART: r_state <= (i_cfg.max_depth == '0) ? S_DC_MUL : S_LOOK;
                S_LOOK:   r_state <= S_TEST;
                S_TEST: begin
                    if (!(r_out || r_cell) && (r_d < {1'b0, i_cfg.max_depth})) begin
                        r_state <= S_LOOK;
                    end else begin
                        r_state <= S_DC_MUL;
                    end
                end
                S_DC_MUL: r_state <= (w_dd == '0) ? S_FIN : S_DC_GO;
                S_DC_GO:  r_state <= S_DC_WT;
                S_DC_WT: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x <= i_req.column_x;
            end
            S_NUM0: begin
                r_num <= DW'(32'(w_w) * 32'(w_k));
            end
            S_NUM1: begin
                r_num <= r_num + $unsigned(DW'(w_span_prod));
            end
            S_DQ_WT: begin
                r_phase <= 17'(w_div_q[ANG_W-1:0]) << (17 - ANG_W);
                r_cos   <= 1'b0;
            end
            S_TZ: begin
                r_z   <= w_z;
                r_neg <= w_ph[16];
                r_z2  <= 16'(w_p0 >> 15);
            end
            S_T1: begin
                r_r <= 16'(w_p1 >> 15);
            end
            S_T2: begin
                r_r <= 16'(w_p2 >> 15);
            end
            S_T3: begin
                r_s <= r_neg ? -$signed(w_s) : $signed(w_s);
            end
            S_TSTEP: begin
                if (r_cos) begin
                    r_dy <= w_sprod;
                end else begin
                    r_dx  <= w_sprod;
                    r_cos <= 1'b1;
                end
            end
            S_MSTART: begin
                r_px <= $signed({4'b0, i_cfg.viewer_x, 14'b0}) + POS_W'(r_dx);
                r_py <= $signed({4'b0, i_cfg.viewer_y, 14'b0}) + POS_W'(r_dy);
                r_d  <= (i_cfg.max_depth == '0) ? 17'd0 : {6'b0, w_step};
            end
            S_LOOK: begin
                r_out <= w_outside;
            end
            S_TEST: begin
                if (r_out) begin
                    r_d <= {1'b0, i_cfg.max_depth};
                end else if (!r_cell && (r_d < {1'b0, i_cfg.max_depth})) begin
                    r_d  <= r_d + {6'b0, w_step};
                    r_px <= r_px + POS_W'(r_dx);
                    r_py <= r_py + POS_W'(r_dy);
                end
            end
            S_DC_MUL: begin
                r_dd   <= w_dd;
                r_cnum <= w_cnum;
                r_zero <= (w_dd == '0);
            end
            S_DC_GO: begin
                r_cneg <= r_cnum[30];
            end
            S_DC_WT: begin
                r_c <= r_cneg ? -$signed({1'b0, w_div_q[21:0]}) : $signed({1'b0, w_div_q[21:0]});
            end
            default: begin
            end
        endcase

        if (w_load) begin
            r_o_col  <= r_x;
            r_o_dist <= r_dd;
            if (r_zero) begin
                r_o_ceil  <= -16'sd32768;
                r_o_floor <= 16'hFFFF;
            end else begin
                r_o_ceil  <= (r_c < C_MIN) ? -16'sd32768 : r_c[15:0];
                r_o_floor <= (w_floor > 24'sd65535) ? 16'hFFFF : w_floor[15:0];
            end
            if (w_dd4 <= w_max) begin
                r_o_red <= 8'd136; r_o_green <= 8'd69; r_o_blue <= 8'd53;
            end else if (w_dd3 < w_max) begin
                r_o_red <= 8'd99;  r_o_green <= 8'd51; r_o_blue <= 8'd39;
            end else if (w_dd2 < w_max) begin
                r_o_red <= 8'd61;  r_o_green <= 8'd31; r_o_blue <= 8'd24;
            end else if ({2'b0, r_dd} < w_max) begin
                r_o_red <= 8'd26;  r_o_green <= 8'd13; r_o_blue <= 8'd10;
            end else begin
                r_o_red <= 8'd138; r_o_green <= 8'd43; r_o_blue <= 8'd227;
            end
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.out_column   = r_o_col;
    assign o_res.hit_distance = r_o_dist;
    assign o_res.ceiling_row  = r_o_ceil;
    assign o_res.floor_row    = r_o_floor;
    assign o_res.wall_red     = r_o_red;
    assign o_res.wall_green   = r_o_green;
    assign o_res.wall_blue    = r_o_blue;

endmodule

>>> hw/rtl/grid_raycast_column.sv
`timescale 1ns / 1ps

// Channel   Direction  Kind        Contents
// i_req     in         valid/ready func, cell_row, cell_col, cell_wall, column_x
// o_res     out        valid/ready out_column, hit_distance, ceiling_row, floor_row, colors
// APB       in/out     psel/pready eight view registers at byte address 4*index
//
// A cell write leaves the queue and updates the map in the same cycle.
// The time a cast takes grows with N, the number of march steps; the serial divider
// (used at most twice) and the map probe per step (look, then test) set it.
// Reset is synchronous and active low; the wall map is not cleared.
// A four-entry queue parts the input from the caster, and the result register lets
// the caster compute the next result while the previous transfer still waits on o_res.ready.

module grid_raycast_column #(
    parameter int MAP_COLS    = grc_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = grc_pkg::MAP_ROWS_DEF,
    parameter int ANGLE_STEPS = grc_pkg::ANGLE_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grc_in_if.sink      i_req,
    grc_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_VIEWER_X  = 3'd0;
    localparam logic [2:0] REG_VIEWER_Y  = 3'd1;
    localparam logic [2:0] REG_HEADING   = 3'd2;
    localparam logic [2:0] REG_SPAN      = 3'd3;
    localparam logic [2:0] REG_MAX_DEPTH = 3'd4;
    localparam logic [2:0] REG_STEP      = 3'd5;
    localparam logic [2:0] REG_WIDTH     = 3'd6;
    localparam logic [2:0] REG_HEIGHT    = 3'd7;

    grc_pkg::t_cfg r_cfg;
    grc_pkg::t_req w_push_data;
    grc_pkg::t_req w_head;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= grc_pkg::CFG_RESET;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_VIEWER_X:  r_cfg.viewer_x      <= pwdata[15:0];
                REG_VIEWER_Y:  r_cfg.viewer_y      <= pwdata[15:0];
                REG_HEADING:   r_cfg.view_heading  <= pwdata[9:0];
                REG_SPAN:      r_cfg.view_span     <= pwdata[9:0];
                REG_MAX_DEPTH: r_cfg.max_depth     <= pwdata[15:0];
                REG_STEP:      r_cfg.march_step    <= pwdata[10:0];
                REG_WIDTH:     r_cfg.screen_width  <= pwdata[11:0];
                REG_HEIGHT:    r_cfg.screen_height <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_VIEWER_X:  prdata = {16'b0, r_cfg.viewer_x};
            REG_VIEWER_Y:  prdata = {16'b0, r_cfg.viewer_y};
            REG_HEADING:   prdata = {22'b0, r_cfg.view_heading};
            REG_SPAN:      prdata = {22'b0, r_cfg.view_span};
            REG_MAX_DEPTH: prdata = {16'b0, r_cfg.max_depth};
            REG_STEP:      prdata = {21'b0, r_cfg.march_step};
            REG_WIDTH:     prdata = {20'b0, r_cfg.screen_width};
            REG_HEIGHT:    prdata = {20'b0, r_cfg.screen_height};
            default:       prdata = '0;
        endcase
    end

    grc_front #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_data (w_push_data)
    );

    grc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    grc_back #(
        .MAP_COLS    (MAP_COLS),
        .MAP_ROWS    (MAP_ROWS),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue read while empty");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !i_req.ready)
        else $error("input ready while queue full");

endmodule

>>> sim/grid_raycast_column_tb.sv
`timescale 1ns / 1ps

module grid_raycast_column_tb;

    typedef enum logic [2:0] {
        REG_VIEWER_X, REG_VIEWER_Y, REG_VIEW_HEADING, REG_VIEW_SPAN,
        REG_MAX_DEPTH, REG_MARCH_STEP, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT
    } t_view_reg;

    typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} t_pace;

    localparam logic FUNC_WRITE_CELL = 1'b0;
    localparam logic FUNC_CAST       = 1'b1;

    typedef struct packed {
        logic        func;
        logic [4:0]  row;
        logic [4:0]  col;
        logic        wall;
        logic [10:0] column_x;
    } t_column_req;

    typedef struct packed {
        logic [10:0]        column;
        logic [15:0]        distance;
        logic signed [15:0] ceiling;
        logic [15:0]        floor;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_column_shade;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grc_in_if  req_if ();
    grc_out_if res_if ();

    grid_raycast_column u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_column_req   pending_reqs[$];
    t_column_shade expected_shades[$];
    grc_pkg::t_cfg view_model = grc_pkg::CFG_RESET;
    bit            wall_cells[grc_pkg::MAP_ROWS_DEF * grc_pkg::MAP_COLS_DEF];
    t_pace         pace = PACE_FREE;
    bit            req_taken;
    int            error_count = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int ray_sine(int unsigned phase);
        int unsigned quad, z, z2, r;
        quad = (phase >> 15) & 3;
        z = phase & 32767;
        if (quad & 1) begin
            z = 32768 - z;
        end
        z2 = (z * z) >> 15;
        r = (32'd1160 * z2) >> 15;
        r = ((32'd10512 - r) * z2) >> 15;
        r = ((32'd25736 - r) * z) >> 15;
        return (quad >= 2) ? -int'(r) : int'(r);
    endfunction

    function automatic t_column_shade trace_column(logic [10:0] x);
        longint w, hd, sp, xl, num, d, md, px, py, vx, vy, h, c, fl;
        int unsigned ang, ph, st;
        int ex, ey;
        bit done;
        t_column_shade r;
        w = (view_model.screen_width == 0) ? 1 : longint'(view_model.screen_width);
        hd = view_model.view_heading;
        sp = view_model.view_span;
        xl = x;
        num = 2 * hd * w + 2 * xl * sp - sp * w + 8 * w * grc_pkg::ANGLE_STEPS_DEF;
        ang = int'((num / (2 * w)) % grc_pkg::ANGLE_STEPS_DEF);
        ph = ((ang * 131072) / grc_pkg::ANGLE_STEPS_DEF) & 131071;
        ex = ray_sine(ph);
        ey = ray_sine((ph + 32768) & 131071);
        st = (view_model.march_step == 0) ? 1 : view_model.march_step;
        md = view_model.max_depth;
        vx = view_model.viewer_x;
        vy = view_model.viewer_y;
        d = 0;
        done = 0;
        while (!done && d < md) begin
            d += st;
            px = vx * 16384 + ex * d;
            py = vy * 16384 + ey * d;
            if (px < 0 || py < 0 || (px >>> 22) >= grc_pkg::MAP_COLS_DEF
                    || (py >>> 22) >= grc_pkg::MAP_ROWS_DEF) begin
                done = 1;
                d = md;
            end else if (wall_cells[(py >>> 22) * grc_pkg::MAP_COLS_DEF + (px >>> 22)]) begin
                done = 1;
            end
        end
        if (d > 65535) begin
            d = 65535;
        end
        h = view_model.screen_height;
        if (d == 0) begin
            r.ceiling = -16'sd32768;
            r.floor = 16'hFFFF;
        end else begin
            c = (h * d - 512 * h) / (2 * d);
            fl = h - c + 48;
            r.floor = (fl > 65535) ? 16'hFFFF : fl[15:0];
            r.ceiling = (c < -32768) ? -16'sd32768 : c[15:0];
        end
        if (4 * d <= md) begin
            {r.red, r.green, r.blue} = {8'd136, 8'd69, 8'd53};
        end else if (3 * d < md) begin
            {r.red, r.green, r.blue} = {8'd99, 8'd51, 8'd39};
        end else if (2 * d < md) begin
            {r.red, r.green, r.blue} = {8'd61, 8'd31, 8'd24};
        end else if (d < md) begin
            {r.red, r.green, r.blue} = {8'd26, 8'd13, 8'd10};
        end else begin
            {r.red, r.green, r.blue} = {8'd138, 8'd43, 8'd227};
        end
        r.column = x;
        r.distance = d[15:0];
        return r;
    endfunction

    function automatic bit pace_roll(bit sender_side);
        int pct;
        pct = 0;
        if (pace == PACE_BOTH) begin
            pct = 22;
        end else if (sender_side && pace == PACE_SENDER_IDLE) begin
            pct = 86;
        end else if (!sender_side && pace == PACE_RECEIVER_STALL) begin
            pct = 86;
        end
        return $urandom_range(0, 99) < pct;
    endfunction

    always @(negedge i_clk) begin
        t_column_req nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() > 0 && !pace_roll(1'b1)) begin
                nxt = pending_reqs.pop_front();
                req_if.valid     <= 1'b1;
                req_if.func      <= nxt.func;
                req_if.cell_row  <= nxt.row;
                req_if.cell_col  <= nxt.col;
                req_if.cell_wall <= nxt.wall;
                req_if.column_x  <= nxt.column_x;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        res_if.ready <= i_rst_n && !pace_roll(1'b0);
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_column_shade exp_s;
        req_taken <= req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            if (req_if.func == FUNC_CAST) begin
                expected_shades.push_back(trace_column(req_if.column_x));
            end else begin
                wall_cells[req_if.cell_row * grc_pkg::MAP_COLS_DEF + req_if.cell_col] =
                    req_if.cell_wall;
            end
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_shades.size() == 0) begin
                $display("%0t: result for column %0d with none expected", $time,
                         res_if.out_column);
                error_count++;
            end else begin
                exp_s = expected_shades.pop_front();
                check_field("out_column", exp_s.column, res_if.out_column);
                check_field("hit_distance", exp_s.distance, res_if.hit_distance);
                check_field("ceiling_row", exp_s.ceiling, res_if.ceiling_row);
                check_field("floor_row", exp_s.floor, res_if.floor_row);
                check_field("wall_red", exp_s.red, res_if.wall_red);
                check_field("wall_green", exp_s.green, res_if.wall_green);
                check_field("wall_blue", exp_s.blue, res_if.wall_blue);
            end
        end
    end

    task automatic write_reg(t_view_reg idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_view(grc_pkg::t_cfg c);
        write_reg(REG_VIEWER_X, 32'(c.viewer_x));
        write_reg(REG_VIEWER_Y, 32'(c.viewer_y));
        write_reg(REG_VIEW_HEADING, 32'(c.view_heading));
        write_reg(REG_VIEW_SPAN, 32'(c.view_span));
        write_reg(REG_MAX_DEPTH, 32'(c.max_depth));
        write_reg(REG_MARCH_STEP, 32'(c.march_step));
        write_reg(REG_SCREEN_WIDTH, 32'(c.screen_width));
        write_reg(REG_SCREEN_HEIGHT, 32'(c.screen_height));
        view_model = c;
    endtask

    task automatic queue_req(logic func, logic [4:0] row, logic [4:0] col, logic wall,
                             logic [10:0] x);
        pending_reqs.push_back('{func: func, row: row, col: col, wall: wall, column_x: x});
    endtask

    task automatic fill_map(int wall_pct);
        for (int r = 0; r < grc_pkg::MAP_ROWS_DEF; r++) begin
            for (int c = 0; c < grc_pkg::MAP_COLS_DEF; c++) begin
                queue_req(FUNC_WRITE_CELL, 5'(r), 5'(c), $urandom_range(0, 99) < wall_pct,
                          11'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_if.valid || expected_shades.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_burst(int count, t_pace mode, int cast_pct);
        logic [10:0] x;
        pace = mode;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                x = 11'($urandom);
            end else begin
                x = 11'($urandom_range(0, view_model.screen_width - 1));
            end
            queue_req($urandom_range(0, 99) < cast_pct, 5'($urandom), 5'($urandom),
                      1'($urandom_range(0, 2) == 0), x);
        end
        wait_idle();
    endtask

    function automatic grc_pkg::t_cfg random_view();
        grc_pkg::t_cfg c;
        c.viewer_x      = 16'($urandom_range(256, 7936));
        c.viewer_y      = 16'($urandom_range(256, 7936));
        c.view_heading  = 10'($urandom);
        c.view_span     = 10'($urandom_range(1, 512));
        c.max_depth     = 16'($urandom_range(256, 16384));
        c.march_step    = 11'($urandom_range(13, 300));
        c.screen_width  = 12'($urandom_range(1, 2048));
        c.screen_height = 12'($urandom_range(1, 2048));
        return c;
    endfunction

    initial begin
        grc_pkg::t_cfg c;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_WRITE_CELL;
        req_if.cell_row = '0;
        req_if.cell_col = '0;
        req_if.cell_wall = 1'b0;
        req_if.column_x = '0;
        res_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Every cell is written before the first cast reads the map.
        fill_map(20);
        queue_req(FUNC_WRITE_CELL, 5'd31, 5'd31, 1'b1, 11'd0);
        queue_req(FUNC_WRITE_CELL, 5'd0, 5'd0, 1'b1, 11'd2047);
        queue_req(FUNC_WRITE_CELL, 5'd16, 5'd16, 1'b0, 11'd0);
        queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'd0);
        queue_req(FUNC_CAST, 5'd31, 5'd31, 1'b1, 11'd2047);
        queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'd320);
        queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'd639);
        queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'd640);
        queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'd1024);
        wait_idle();

        // A short depth, so rays that miss run out and overshoot it.
        c = grc_pkg::CFG_RESET;
        c.max_depth = 16'd2048;
        load_view(c);
        for (int i = 0; i < 12; i++) begin
            queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'($urandom_range(0, 639)));
        end
        wait_idle();

        // Unit steps with the deepest depth.
        c = '{viewer_x: 16'd3000, viewer_y: 16'd5000, view_heading: 10'd100,
              view_span: 10'd512, max_depth: 16'd65535, march_step: 11'd1,
              screen_width: 12'd16, screen_height: 12'd2048};
        load_view(c);
        for (int i = 0; i < 4; i++) begin
            queue_req(FUNC_CAST, 5'd0, 5'd0, 1'b0, 11'($urandom_range(0, 15)));
        end
        wait_idle();

        c = '{viewer_x: 16'd0, viewer_y: 16'd65535, view_heading: 10'd1023,
              view_span: 10'd512, max_depth: 16'd65535, march_step: 11'd1024,
              screen_width: 12'd2048, screen_height: 12'd1};
        load_view(c);
        random_burst(20, PACE_RECEIVER_STALL, 85);

        c = '{viewer_x: 16'd65535, viewer_y: 16'd0, view_heading: 10'd0,
              view_span: 10'd1, max_depth: 16'd256, march_step: 11'd1,
              screen_width: 12'd1, screen_height: 12'd2048};
        load_view(c);
        random_burst(15, PACE_BOTH, 85);

        c.viewer_x = 16'd4100;
        c.viewer_y = 16'd4100;
        load_view(c);
        random_burst(20, PACE_FREE, 85);

        for (int p = 0; p < 8; p++) begin
            load_view(random_view());
            random_burst(5, t_pace'(p % 4), 85);
        end

        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("grid_raycast_column_tb: clean");
        end else begin
            $display("grid_raycast_column_tb: errors");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("grid_raycast_column_tb: errors");
        $finish;
    end

endmodule
